// File: rtl/dcpwc_pkg.sv
package dcpwc_pkg;

  localparam int unsigned NumChan = 2;
  localparam int unsigned CfgWidth = 16;
  localparam int unsigned ValueWidth = 16;
  localparam int unsigned OvfWidth = 6;
  localparam int unsigned InDataWidth = 8;
  localparam int unsigned OutDataWidth = 48;
  localparam int unsigned AddrWidth = 3;

  localparam logic [CfgWidth-1:0] PeriodReset = 16'hFFFF;
  localparam logic [CfgWidth-1:0] PrescaleReset = 16'h0000;
  localparam logic [ValueWidth-1:0] SatValue = 16'hFFFF;

  // register index, taken from paddr[2]
  typedef enum logic {
    RegPeriod   = 1'b0,
    RegPrescale = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CfgWidth-1:0] period;
    logic [CfgWidth-1:0] prescale;
  } cfg_t;

  typedef struct packed {
    logic [NumChan-1:0] clear;
    logic [NumChan-1:0] pin;
  } item_t;

  typedef struct packed {
    logic                  done;
    logic                  armed;
    logic [OvfWidth-1:0]   overflows;
    logic [ValueWidth-1:0] value;
  } chan_status_t;

endpackage

// File: rtl/dcpwc_apb_regs.sv
module dcpwc_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcpwc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output dcpwc_pkg::cfg_t               cfg_o
);
  import dcpwc_pkg::*;

  logic [CfgWidth-1:0] period_q, prescale_q;
  logic                wr_en;
  reg_idx_e            idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PeriodReset;
      prescale_q <= PrescaleReset;
    end else if (wr_en) begin
      case (idx)
        RegPeriod:   period_q   <= pwdata[CfgWidth-1:0];
        RegPrescale: prescale_q <= pwdata[CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegPeriod:   prdata = 32'(period_q);
      RegPrescale: prdata = 32'(prescale_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.period   = period_q;
  assign cfg_o.prescale = prescale_q;

endmodule

// File: rtl/dcpwc_core.sv
module dcpwc_core #(
  parameter int unsigned COUNT_WIDTH   = 16,
  parameter int unsigned OVERFLOW_BITS = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  dcpwc_pkg::item_t        item_i,
  input  dcpwc_pkg::cfg_t         cfg_i,
  output dcpwc_pkg::chan_status_t [dcpwc_pkg::NumChan-1:0] status_o
);
  import dcpwc_pkg::*;

  localparam logic [OVERFLOW_BITS-1:0] OvfMax = '1;
  localparam logic [COUNT_WIDTH-1:0]   SatCount = COUNT_WIDTH'(SatValue);

  logic [CfgWidth-1:0]    presc_cnt_q, presc_cnt_d;
  logic [COUNT_WIDTH-1:0] main_q, main_d, main_adv, period_lim;
  logic [NumChan-1:0]     prev_q;
  logic [NumChan-1:0]     done_q, done_d, armed_q, armed_d, rise;
  logic [OVERFLOW_BITS-1:0] ovf_q [NumChan];
  logic [OVERFLOW_BITS-1:0] ovf_d [NumChan];
  logic [COUNT_WIDTH-1:0]   val_q [NumChan];
  logic [COUNT_WIDTH-1:0]   val_d [NumChan];
  logic                     adv, upd;

  assign period_lim = COUNT_WIDTH'(cfg_i.period);

  // shared prescaled counter
  always_comb begin
    adv         = presc_cnt_q >= cfg_i.prescale;
    upd         = adv && (main_q >= period_lim);
    presc_cnt_d = adv ? '0 : presc_cnt_q + 1'b1;
    if (!adv)     main_adv = main_q;
    else if (upd) main_adv = '0;
    else          main_adv = main_q + 1'b1;
  end

  // per-channel update: clear, then wrap event, then pin edge
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      done_d[c]  = done_q[c] & ~item_i.clear[c];
      armed_d[c] = armed_q[c] & ~item_i.clear[c];
      ovf_d[c]   = item_i.clear[c] ? '0 : ovf_q[c];
      val_d[c]   = val_q[c];
      rise[c]    = 1'b0;
      if (!done_d[c]) begin
        if (upd && armed_d[c]) begin
          if (ovf_d[c] == OvfMax) begin
            done_d[c] = 1'b1;
            val_d[c]  = SatCount;
          end else begin
            ovf_d[c] = ovf_d[c] + 1'b1;
          end
        end
        if (armed_d[c]) begin
          if (prev_q[c] && !item_i.pin[c]) begin
            done_d[c] = 1'b1;
            val_d[c]  = main_adv;
          end
        end else if (!prev_q[c] && item_i.pin[c]) begin
          done_d[c]  = 1'b0;
          ovf_d[c]   = '0;
          val_d[c]   = '0;
          armed_d[c] = 1'b1;
          rise[c]    = 1'b1;
        end
      end
    end
    main_d = (|rise) ? '0 : main_adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_cnt_q <= '0;
      main_q      <= '0;
      prev_q      <= '0;
      done_q      <= '0;
      armed_q     <= '0;
      for (int c = 0; c < NumChan; c++) begin
        ovf_q[c] <= '0;
        val_q[c] <= '0;
      end
    end else if (step_i) begin
      presc_cnt_q <= presc_cnt_d;
      main_q      <= main_d;
      prev_q      <= item_i.pin;
      done_q      <= done_d;
      armed_q     <= armed_d;
      for (int c = 0; c < NumChan; c++) begin
        ovf_q[c] <= ovf_d[c];
        val_q[c] <= val_d[c];
      end
    end
  end

  // status after this tick, ready for the result register
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      status_o[c].done      = done_d[c];
      status_o[c].armed     = armed_d[c];
      status_o[c].overflows = OvfWidth'(ovf_d[c]);
      status_o[c].value     = ValueWidth'(val_d[c]);
    end
  end

  a_done_needs_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((done_q & ~armed_q) == '0))
    else $error("channel done without being armed");

  a_ovf_needs_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ovf_q[0] == '0 || armed_q[0]) && (ovf_q[1] == '0 || armed_q[1])))
    else $error("overflows counted on an idle channel");

  a_rise_resets_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (|rise)) |=> (main_q == '0))
    else $error("counter not reset by rising edge");

  a_levels_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> (prev_q == $past(item_i.pin)))
    else $error("previous pin levels not updated");

endmodule

// File: rtl/dual_channel_pulse_width_capture.sv
// Dual-channel pulse-width capture.
// Each input word on s_axis is one timer tick: the two pin levels and the two
// clear strobes that return a channel to idle. For every word the block returns one
// result word on m_axis with done, armed, overflow count and captured value of
// both channels, as they stand after that tick.
// Configuration (period, prescale) is written over the APB port at byte addresses 0
// and 4; the user must write it only while no word is in flight, the block does not enforce it.
// On its way to m_axis_tvalid an accepted word is held in the input register, then
// the capture logic updates its state and loads the result register. Throughput is
// one word per cycle while m_axis_tready stays high; the state update is a
// single pass of compare/increment logic per tick.
// When m_axis_tready is low the result register holds its word and the input
// register still takes one more word if it is empty; s_axis_tready drops after that.
// Reset clears the counters, pin history and channel status, and loads period
// with 65535 and prescale with 0.
module dual_channel_pulse_width_capture #(
  parameter int unsigned COUNT_WIDTH   = 16,
  parameter int unsigned OVERFLOW_BITS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pin_one, pin_two, clear_one, clear_two, zero pad
  input  logic [dcpwc_pkg::InDataWidth-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // done_one, armed_one, overflows_one[6], value_one[16],
  // done_two, armed_two, overflows_two[6], value_two[16]
  output logic [dcpwc_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dcpwc_pkg::AddrWidth-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import dcpwc_pkg::*;

  cfg_t                        cfg;
  item_t                       in_q;
  logic                        in_valid_q, out_valid_q, step;
  chan_status_t [NumChan-1:0]  status;
  logic [OutDataWidth-1:0]     out_q, out_d;

  dcpwc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input word present and result register free or being drained this cycle
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (step)               out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.pin   <= s_axis_tdata[1:0];
      in_q.clear <= s_axis_tdata[3:2];
    end
    if (step) out_q <= out_d;
  end

  dcpwc_core #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .OVERFLOW_BITS (OVERFLOW_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .status_o (status)
  );

  assign out_d = {status[1].value, status[1].overflows, status[1].armed, status[1].done,
                  status[0].value, status[0].overflows, status[0].armed, status[0].done};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// File: dv/pwc_capture_checker.sv
`timescale 1ns / 1ps

module pwc_capture_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  // pin_one, pin_two, clear_one, clear_two, zero pad
  input  logic [dcpwc_pkg::InDataWidth-1:0]  s_axis_tdata,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // done_one, armed_one, overflows_one[6], value_one[16],
  // done_two, armed_two, overflows_two[6], value_two[16]
  input  logic [dcpwc_pkg::OutDataWidth-1:0] m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dcpwc_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  input  logic                               pready,
  output int                                 fail_count,
  output int                                 pending
);
  import dcpwc_pkg::*;

  localparam int unsigned ChanBits = 2 + OvfWidth + ValueWidth;
  localparam logic [OvfWidth-1:0] OvfTop = '1;

  typedef struct packed {
    chan_status_t two;
    chan_status_t one;
  } tick_status_t;

  logic [CfgWidth-1:0]   period_q;
  logic [CfgWidth-1:0]   prescale_q;
  logic [CfgWidth-1:0]   presc_cnt;
  logic [ValueWidth-1:0] main_cnt;
  logic [NumChan-1:0]    prev_pins;
  chan_status_t          chan [NumChan];
  tick_status_t          status_q [$];
  int                    results_seen;

  // One timer tick: clears, counter advance, then per channel update before edges.
  function automatic tick_status_t advance_tick(item_t w);
    logic                  wrap;
    logic                  restart;
    logic [ValueWidth-1:0] snap;
    tick_status_t          r;
    wrap = 1'b0;
    restart = 1'b0;
    for (int c = 0; c < NumChan; c++) begin
      if (w.clear[c]) begin
        chan[c].done = 1'b0;
        chan[c].armed = 1'b0;
        chan[c].overflows = '0;
      end
    end
    if (presc_cnt >= prescale_q) begin
      presc_cnt = '0;
      if (main_cnt >= period_q) begin
        main_cnt = '0;
        wrap = 1'b1;
      end else begin
        main_cnt = main_cnt + 1'b1;
      end
    end else begin
      presc_cnt = presc_cnt + 1'b1;
    end
    snap = main_cnt;
    for (int c = 0; c < NumChan; c++) begin
      if (!chan[c].done) begin
        if (wrap && chan[c].armed) begin
          if (chan[c].overflows == OvfTop) begin
            chan[c].done = 1'b1;
            chan[c].value = SatValue;
          end else begin
            chan[c].overflows = chan[c].overflows + 1'b1;
          end
        end
        // a falling edge may still land on the saturating tick and win
        if (chan[c].armed) begin
          if (prev_pins[c] && !w.pin[c]) begin
            chan[c].done = 1'b1;
            chan[c].value = snap;
          end
        end else if (!prev_pins[c] && w.pin[c]) begin
          chan[c].overflows = '0;
          chan[c].value = '0;
          chan[c].armed = 1'b1;
          restart = 1'b1;
        end
      end
    end
    if (restart) begin
      main_cnt = '0;
    end
    prev_pins = w.pin;
    r.one = chan[0];
    r.two = chan[1];
    return r;
  endfunction

  function automatic chan_status_t unpack_chan(logic [ChanBits-1:0] s);
    chan_status_t r;
    r.done = s[0];
    r.armed = s[1];
    r.overflows = s[OvfWidth+1:2];
    r.value = s[ChanBits-1:OvfWidth+2];
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic compare_chan(input string name, input chan_status_t got,
                              input chan_status_t want);
    if (got.done !== want.done) begin
      flag_mismatch($sformatf("word %0d done_%s got %0h want %0h",
                              results_seen, name, got.done, want.done));
    end
    if (got.armed !== want.armed) begin
      flag_mismatch($sformatf("word %0d armed_%s got %0h want %0h",
                              results_seen, name, got.armed, want.armed));
    end
    if (got.overflows !== want.overflows) begin
      flag_mismatch($sformatf("word %0d overflows_%s got %0d want %0d",
                              results_seen, name, got.overflows, want.overflows));
    end
    if (got.value !== want.value) begin
      flag_mismatch($sformatf("word %0d value_%s got %0h want %0h",
                              results_seen, name, got.value, want.value));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_status_t want;
    tick_status_t got;
    if (!rst_ni) begin
      period_q = PeriodReset;
      prescale_q = PrescaleReset;
      presc_cnt = '0;
      main_cnt = '0;
      prev_pins = '0;
      foreach (chan[c]) chan[c] = '0;
      status_q.delete();
      results_seen = 0;
      pending <= 0;
    end else begin
      // results first, so a word can never match an expectation pushed on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.one = unpack_chan(m_axis_tdata[ChanBits-1:0]);
        got.two = unpack_chan(m_axis_tdata[2*ChanBits-1:ChanBits]);
        if (status_q.size() == 0) begin
          flag_mismatch($sformatf("word %0d arrived with nothing expected", results_seen));
        end else begin
          want = status_q.pop_front();
          compare_chan("one", got.one, want.one);
          compare_chan("two", got.two, want.two);
        end
        results_seen++;
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          RegPeriod:   period_q = pwdata[CfgWidth-1:0];
          RegPrescale: prescale_q = pwdata[CfgWidth-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        status_q.push_back(advance_tick(item_t'(s_axis_tdata[$bits(item_t)-1:0])));
      end
      pending <= status_q.size();
    end
  end

endmodule

// File: dv/dual_channel_pulse_width_capture_test.sv
`timescale 1ns / 1ps

module dual_channel_pulse_width_capture_test;
  import dcpwc_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned SegCount = 6;
  localparam int unsigned SegItems = 185;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned DirectedCount = 20;

  // {clear_two, clear_one, pin_two, pin_one} per tick, first tick in the top nibble
  localparam logic [4*DirectedCount-1:0] DirectedTicks = {
    4'b0000,  // both low
    4'b0011,  // both rise at once: both arm, counter restarts once
    4'b0011,
    4'b0010,  // channel one falls: capture
    4'b0011,  // channel one done, its rising edge is ignored
    4'b0000,  // channel two falls: capture; channel one falling ignored
    4'b0101,  // clear one together with a rising edge: rearms at once
    4'b1000,  // clear two while done
    4'b0101,  // clear one while done, with a rising edge: rearms at once
    4'b0000,
    4'b0011,
    4'b1111,  // clear both while high: channel two armed, channel one done
    4'b0000,
    4'b0001,  // one rises alone
    4'b0011,  // two rises: shared counter restarts while one measures
    4'b0001,
    4'b0000,
    4'b1100,
    4'b0010,
    4'b0000
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [AddrWidth-1:0]    paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  int                  fail_count;
  int                  pending;
  int                  send_idle_pct = 31;
  int                  recv_idle_pct = 59;
  int unsigned         cyc = 0;
  int unsigned         quiet = 0;
  logic [CfgWidth-1:0] cur_period = PeriodReset;
  logic [CfgWidth-1:0] cur_prescale = PrescaleReset;
  logic [NumChan-1:0]  pin_level = '0;
  int                  run_left [NumChan] = '{0, 0};

  dual_channel_pulse_width_capture u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  pwc_capture_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .pready,
    .fail_count,
    .pending
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // result side backpressure, with regular stretches of none
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc % 128 < 24) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (psel && pready)) begin
      quiet <= 0;
    end else if (quiet == StallLimit) begin
      $display("dual_channel_pulse_width_capture_test NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input item_t w, input bit gaps_ok);
    while (gaps_ok && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataWidth - $bits(item_t)){1'b0}}, w};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgWidth-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CfgWidth-1:0] per, input logic [CfgWidth-1:0] pre);
    write_reg(RegPeriod, per);
    write_reg(RegPrescale, pre);
    cur_period = per;
    cur_prescale = pre;
  endtask

  // Pulse trains per pin; some high runs are sized to end right around saturation.
  function automatic item_t next_item();
    item_t           w;
    longint unsigned sat_len;
    sat_len = 64 * (longint'(cur_period) + 1) * (longint'(cur_prescale) + 1);
    for (int c = 0; c < NumChan; c++) begin
      w.clear[c] = (!pin_level[c] && $urandom_range(0, 3) == 0) || $urandom_range(0, 255) == 0;
      if (run_left[c] == 0) begin
        pin_level[c] = ~pin_level[c];
        if (pin_level[c] && sat_len <= 512 && $urandom_range(0, 4) == 0) begin
          run_left[c] = int'(sat_len) + int'($urandom_range(0, 6)) - 3;
        end else begin
          run_left[c] = $urandom_range(1, 12);
        end
      end
      run_left[c]--;
      w.pin[c] = pin_level[c];
    end
    if ($urandom_range(0, 9) == 0) begin
      w = item_t'(4'($urandom_range(0, 15)));
    end
    return w;
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(16'd2, 16'd0);
    for (int i = 0; i < DirectedCount; i++) begin
      send_item(item_t'(DirectedTicks[4*(DirectedCount-1-i) +: 4]), 1'b1);
    end
    drain_results();

    for (int seg = 0; seg < SegCount; seg++) begin
      case (seg)
        0: configure(16'd0, 16'd0);
        1: configure(16'd1, 16'd0);
        2: begin
          send_idle_pct = 59;
          recv_idle_pct = 31;
          configure(16'd2, 16'd1);
        end
        3: configure(16'hFFFF, 16'hFFFF);
        4: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          configure(16'($urandom_range(3, 12)), 16'($urandom_range(0, 2)));
        end
        default: configure(16'd5, 16'd0);
      endcase
      for (int n = 0; n < SegItems; n++) begin
        // hold the stream until every pending word is back
        if (n == SegItems / 2) begin
          drain_results();
        end
        send_item(next_item(), (n % 64) >= 16);
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("dual_channel_pulse_width_capture_test OK");
    end else begin
      $display("dual_channel_pulse_width_capture_test NOT OK");
    end
    $finish;
  end

endmodule
